// ===== rtl/core/ldt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ldt_pkg
// Shared widths, codes and reset values for the local density threshold block.
// ----------------------------------------------------------------------------
package ldt_pkg;

   localparam int COORD_W      = 11;
   localparam int RAD_W        = 3;
   localparam int PCT_W        = 7;
   localparam int SUM_W        = 8;
   localparam int AREA_W       = 8;
   localparam int SPAN_W       = 4;
   localparam int PROD_W       = 15;
   localparam int STATUS_W     = 2;
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 11;
   localparam int DEF_MAX_SIZE = 1024;

   localparam logic [COORD_W-1:0] RESET_IMAGE_SIZE = 11'd1024;
   localparam logic [RAD_W-1:0]   RESET_RADIUS     = 3'd3;
   localparam logic [PCT_W-1:0]   RESET_PERCENT    = 7'd37;
   localparam logic [PCT_W-1:0]   SCALE            = 7'd100;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_SIZE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PERCENT    = 2'd2;

   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK         = 2'd0,
      STATUS_RANGE      = 2'd1,
      STATUS_INCOMPLETE = 2'd2
   } status_type;

endpackage
`default_nettype wire

// ===== rtl/core/local_density_threshold_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// local_density_threshold_top
// Summed-area table over a loaded binary image, with windowed density query.
// ----------------------------------------------------------------------------
// Load transactions (req_type 0) stream an image of image_size x image_size
// pixels in raster order; each reads the entry above, then writes its own
// entry, both on the single table port, before the block is ready again.
// Loads after the image is complete are accepted and dropped. A query
// (req_type 1) steps through bounds, four table reads through the same port
// folded by one add/subtract accumulator, the two products, then the result
// register; an error query goes from bounds to the result register. One
// transaction is in work at a time. The table has no clearing pass: a query
// after a full image load reads only entries written by that load. Writing
// image_size restarts the load at the first pixel, except in a pixel write.
// ----------------------------------------------------------------------------
module local_density_threshold_top #(
   parameter int MAX_SIZE = ldt_pkg::DEF_MAX_SIZE
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic                              req_type,
   input  wire logic                              req_pixel_value,
   input  wire logic [ldt_pkg::COORD_W-1:0]       req_query_row,
   input  wire logic [ldt_pkg::COORD_W-1:0]       req_query_col,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic                                   rsp_dense,
   output logic      [ldt_pkg::SUM_W-1:0]         rsp_window_sum,
   output logic      [ldt_pkg::AREA_W-1:0]        rsp_window_area,
   output logic      [ldt_pkg::STATUS_W-1:0]      rsp_status,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [ldt_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [ldt_pkg::CSR_DATA_W-1:0]    csr_data
);

   localparam int IDX_W  = $clog2(MAX_SIZE);
   localparam int DEPTH  = MAX_SIZE * MAX_SIZE;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int TBL_W  = 2 * IDX_W + 1;
   localparam int CW     = ldt_pkg::COORD_W;
   localparam int CW1    = ldt_pkg::COORD_W + 1;
   localparam logic [1:0] LAST_TERM = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LD_READ,
      ST_LD_WRITE,
      ST_BOUNDS,
      ST_READ,
      ST_LAST,
      ST_PROD,
      ST_DONE
   } state_type;

   state_type                      state_ff, state_in;
   logic [CW-1:0]                  image_size_ff, image_size_in;
   logic [ldt_pkg::RAD_W-1:0]      radius_ff, radius_in;
   logic [ldt_pkg::PCT_W-1:0]      percent_ff, percent_in;
   logic [CW-1:0]                  load_row_ff, load_row_in;
   logic [CW-1:0]                  load_col_ff, load_col_in;
   logic [CW-1:0]                  running_ff, running_in;
   logic                           complete_ff, complete_in;
   logic [CW-1:0]                  q_row_ff, q_row_in;
   logic [CW-1:0]                  q_col_ff, q_col_in;
   logic [CW-1:0]                  x2_ff, x2_in;
   logic [CW-1:0]                  y2_ff, y2_in;
   logic [CW-1:0]                  x1m1_ff, x1m1_in;
   logic [CW-1:0]                  y1m1_ff, y1m1_in;
   logic [1:0]                     rd_idx_ff, rd_idx_in;
   logic [1:0]                     pend_idx_ff, pend_idx_in;
   logic                           pend_ff, pend_in;
   logic [ldt_pkg::SUM_W-1:0]      acc_ff, acc_in;
   logic [ldt_pkg::AREA_W-1:0]     area_ff, area_in;
   logic [ldt_pkg::PROD_W-1:0]     lhs_ff, lhs_in;
   logic [ldt_pkg::PROD_W-1:0]     rhs_ff, rhs_in;
   ldt_pkg::status_type            status_ff, status_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           rsp_dense_ff, rsp_dense_in;
   logic [ldt_pkg::SUM_W-1:0]      rsp_sum_ff, rsp_sum_in;
   logic [ldt_pkg::AREA_W-1:0]     rsp_area_ff, rsp_area_in;
   logic [ldt_pkg::STATUS_W-1:0]   rsp_status_ff, rsp_status_in;

   logic [CW-1:0]                  eff_n;
   logic [CW1-1:0]                 row_w, col_w, rad_w, n_w;
   logic [CW1-1:0]                 x1_w, y1_w, x2_w, y2_w;
   logic                           coord_bad;
   logic [CW-1:0]                  rd_row, rd_col, acc_row, acc_col;
   logic                           acc_zero, acc_sub;
   logic [ldt_pkg::SUM_W-1:0]      acc_op, acc_next;
   logic [ldt_pkg::SPAN_W-1:0]     span_h, span_w;

   logic                           ram_en, ram_we;
   logic [ADDR_W-1:0]              ram_addr;
   logic [TBL_W-1:0]               ram_wdata, ram_rdata;

   function automatic logic [ADDR_W-1:0] table_addr(input logic [CW-1:0] row1,
                                                    input logic [CW-1:0] col1);
      return ADDR_W'(IDX_W'(row1 - CW'(1))) * ADDR_W'(MAX_SIZE)
           + ADDR_W'(IDX_W'(col1 - CW'(1)));
   endfunction

   ldt_table #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W),
      .DATA_W (TBL_W)
   ) u_table (
      .clock (clock),
      .en    (ram_en),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   always_comb begin
      if (image_size_ff == '0) begin
         eff_n = CW'(1);
      end else if (int'(image_size_ff) > MAX_SIZE) begin
         eff_n = CW'(MAX_SIZE);
      end else begin
         eff_n = image_size_ff;
      end
   end

   always_comb begin
      row_w = {1'b0, q_row_ff};
      col_w = {1'b0, q_col_ff};
      rad_w = CW1'(radius_ff);
      n_w   = {1'b0, eff_n};
      x1_w  = (row_w > rad_w + CW1'(1)) ? row_w - rad_w : CW1'(1);
      y1_w  = (col_w > rad_w + CW1'(1)) ? col_w - rad_w : CW1'(1);
      x2_w  = (row_w + rad_w < n_w) ? row_w + rad_w : n_w;
      y2_w  = (col_w + rad_w < n_w) ? col_w + rad_w : n_w;
      coord_bad = (q_row_ff == '0) || (q_col_ff == '0) ||
                  (q_row_ff > eff_n) || (q_col_ff > eff_n);
   end

   always_comb begin
      rd_row   = rd_idx_ff[0] ? x1m1_ff : x2_ff;
      rd_col   = rd_idx_ff[1] ? y1m1_ff : y2_ff;
      acc_row  = pend_idx_ff[0] ? x1m1_ff : x2_ff;
      acc_col  = pend_idx_ff[1] ? y1m1_ff : y2_ff;
      acc_zero = (acc_row == '0) || (acc_col == '0);
      acc_sub  = pend_idx_ff[0] ^ pend_idx_ff[1];
      acc_op   = acc_zero ? '0 : ldt_pkg::SUM_W'(ram_rdata);
      acc_next = acc_sub ? acc_ff - acc_op : acc_ff + acc_op;
      span_h   = ldt_pkg::SPAN_W'(x2_ff - x1m1_ff);
      span_w   = ldt_pkg::SPAN_W'(y2_ff - y1m1_ff);
   end

   always_comb begin
      ram_en    = 1'b0;
      ram_we    = 1'b0;
      ram_addr  = table_addr(rd_row, rd_col);
      ram_wdata = ((load_row_ff == CW'(1)) ? '0 : ram_rdata) + TBL_W'(running_ff);
      case (state_ff)
         ST_LD_READ: begin
            ram_en   = 1'b1;
            ram_addr = table_addr(load_row_ff - CW'(1), load_col_ff);
         end
         ST_LD_WRITE: begin
            ram_en   = 1'b1;
            ram_we   = 1'b1;
            ram_addr = table_addr(load_row_ff, load_col_ff);
         end
         ST_READ: begin
            ram_en = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      image_size_in = image_size_ff;
      radius_in     = radius_ff;
      percent_in    = percent_ff;
      load_row_in   = load_row_ff;
      load_col_in   = load_col_ff;
      running_in    = running_ff;
      complete_in   = complete_ff;
      q_row_in      = q_row_ff;
      q_col_in      = q_col_ff;
      x2_in         = x2_ff;
      y2_in         = y2_ff;
      x1m1_in       = x1m1_ff;
      y1m1_in       = y1m1_ff;
      rd_idx_in     = rd_idx_ff;
      pend_idx_in   = pend_idx_ff;
      pend_in       = pend_ff;
      acc_in        = acc_ff;
      area_in       = area_ff;
      lhs_in        = lhs_ff;
      rhs_in        = rhs_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_dense_in  = rsp_dense_ff;
      rsp_sum_in    = rsp_sum_ff;
      rsp_area_in   = rsp_area_ff;
      rsp_status_in = rsp_status_ff;

      if (csr_valid) begin
         case (csr_index)
            ldt_pkg::CSR_IMAGE_SIZE: begin
               image_size_in = csr_data;
               load_row_in   = CW'(1);
               load_col_in   = CW'(1);
               running_in    = '0;
               complete_in   = 1'b0;
            end
            ldt_pkg::CSR_RADIUS: begin
               radius_in = csr_data[ldt_pkg::RAD_W-1:0];
            end
            ldt_pkg::CSR_PERCENT: begin
               percent_in = csr_data[ldt_pkg::PCT_W-1:0];
            end
            default: begin
            end
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_type == ldt_pkg::REQ_QUERY) begin
                  q_row_in = req_query_row;
                  q_col_in = req_query_col;
                  state_in = ST_BOUNDS;
               end else if (!complete_ff) begin
                  running_in = running_ff + CW'(req_pixel_value);
                  state_in   = ST_LD_READ;
               end
            end
         end
         ST_LD_READ: begin
            state_in = ST_LD_WRITE;
         end
         ST_LD_WRITE: begin
            if (load_col_ff >= eff_n) begin
               load_col_in = CW'(1);
               running_in  = '0;
               if (load_row_ff >= eff_n) begin
                  complete_in = 1'b1;
               end else begin
                  load_row_in = load_row_ff + CW'(1);
               end
            end else begin
               load_col_in = load_col_ff + CW'(1);
            end
            state_in = ST_IDLE;
         end
         ST_BOUNDS: begin
            acc_in    = '0;
            area_in   = '0;
            lhs_in    = '0;
            rhs_in    = '0;
            rd_idx_in = '0;
            pend_in   = 1'b0;
            if (!complete_ff) begin
               status_in = ldt_pkg::STATUS_INCOMPLETE;
               state_in  = ST_DONE;
            end else if (coord_bad) begin
               status_in = ldt_pkg::STATUS_RANGE;
               state_in  = ST_DONE;
            end else begin
               status_in = ldt_pkg::STATUS_OK;
               x2_in     = CW'(x2_w);
               y2_in     = CW'(y2_w);
               x1m1_in   = CW'(x1_w - CW1'(1));
               y1m1_in   = CW'(y1_w - CW1'(1));
               state_in  = ST_READ;
            end
         end
         ST_READ: begin
            if (pend_ff) begin
               acc_in = acc_next;
            end
            if (rd_idx_ff == '0) begin
               area_in = ldt_pkg::AREA_W'(span_h) * ldt_pkg::AREA_W'(span_w);
            end
            pend_in     = 1'b1;
            pend_idx_in = rd_idx_ff;
            rd_idx_in   = rd_idx_ff + 2'd1;
            if (rd_idx_ff == LAST_TERM) begin
               state_in = ST_LAST;
            end
         end
         ST_LAST: begin
            acc_in   = acc_next;
            pend_in  = 1'b0;
            state_in = ST_PROD;
         end
         ST_PROD: begin
            lhs_in   = ldt_pkg::PROD_W'(acc_ff) * ldt_pkg::PROD_W'(ldt_pkg::SCALE);
            rhs_in   = ldt_pkg::PROD_W'(area_ff) * ldt_pkg::PROD_W'(percent_ff);
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_dense_in  = lhs_ff > rhs_ff;
               rsp_sum_in    = acc_ff;
               rsp_area_in   = area_ff;
               rsp_status_in = status_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      q_row_ff      <= q_row_in;
      q_col_ff      <= q_col_in;
      x2_ff         <= x2_in;
      y2_ff         <= y2_in;
      x1m1_ff       <= x1m1_in;
      y1m1_ff       <= y1m1_in;
      rd_idx_ff     <= rd_idx_in;
      pend_idx_ff   <= pend_idx_in;
      acc_ff        <= acc_in;
      area_ff       <= area_in;
      lhs_ff        <= lhs_in;
      rhs_ff        <= rhs_in;
      status_ff     <= status_in;
      rsp_dense_ff  <= rsp_dense_in;
      rsp_sum_ff    <= rsp_sum_in;
      rsp_area_ff   <= rsp_area_in;
      rsp_status_ff <= rsp_status_in;
      if (reset) begin
         state_ff      <= ST_IDLE;
         image_size_ff <= ldt_pkg::RESET_IMAGE_SIZE;
         radius_ff     <= ldt_pkg::RESET_RADIUS;
         percent_ff    <= ldt_pkg::RESET_PERCENT;
         load_row_ff   <= CW'(1);
         load_col_ff   <= CW'(1);
         running_ff    <= '0;
         complete_ff   <= 1'b0;
         pend_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         image_size_ff <= image_size_in;
         radius_ff     <= radius_in;
         percent_ff    <= percent_in;
         load_row_ff   <= load_row_in;
         load_col_ff   <= load_col_in;
         running_ff    <= running_in;
         complete_ff   <= complete_in;
         pend_ff       <= pend_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   assign req_ready       = (state_ff == ST_IDLE);
   assign csr_ready       = 1'b1;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_dense       = rsp_dense_ff;
   assign rsp_window_sum  = rsp_sum_ff;
   assign rsp_window_area = rsp_area_ff;
   assign rsp_status      = rsp_status_ff;

endmodule
`default_nettype wire

// ===== rtl/core/ldt_table.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ldt_table
// Single-port summed-area table memory with registered read data.
// ----------------------------------------------------------------------------
module ldt_table #(
   parameter int DEPTH  = ldt_pkg::DEF_MAX_SIZE * ldt_pkg::DEF_MAX_SIZE,
   parameter int ADDR_W = $clog2(DEPTH),
   parameter int DATA_W = 21
) (
   input  wire logic              clock,
   input  wire logic              en,
   input  wire logic              we,
   input  wire logic [ADDR_W-1:0] addr,
   input  wire logic [DATA_W-1:0] wdata,
   output logic      [DATA_W-1:0] rdata
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem_ff[addr] <= wdata;
         end else begin
            rdata_ff <= mem_ff[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

// ===== bench/local_density_threshold_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// local_density_threshold_top_tb
// Self-checking bench for the summed-area density threshold block.
// ----------------------------------------------------------------------------
// Streams small binary images into the block under many size, radius and
// percent settings and queries windows around chosen and random centers,
// in range and out of it, before and after the image is complete. Every
// response is checked field by field against an in-bench summed-area table
// kept in step with each accepted transaction. Both handshakes idle at
// random, and one long response hold-off backs the block up into its
// request port.
// ----------------------------------------------------------------------------
module local_density_threshold_top_tb;

   localparam int TABLE_SIDE   = ldt_pkg::DEF_MAX_SIZE;
   localparam int DRAIN_CYCLES = 12;
   localparam int LONG_HOLD    = 400;
   localparam int RANDOM_ITEMS = 600;
   localparam int REPORT_LIMIT = 10;

   typedef struct {
      logic                        kind;
      logic                        pixel;
      logic [ldt_pkg::COORD_W-1:0] row;
      logic [ldt_pkg::COORD_W-1:0] col;
   } pixel_request_type;

   typedef struct packed {
      logic                         dense;
      logic [ldt_pkg::SUM_W-1:0]    window_sum;
      logic [ldt_pkg::AREA_W-1:0]   window_area;
      logic [ldt_pkg::STATUS_W-1:0] status;
   } density_result_type;

   logic                           clock           = 1'b0;
   logic                           reset           = 1'b1;
   logic                           req_valid       = 1'b0;
   logic                           req_type        = ldt_pkg::REQ_LOAD;
   logic                           req_pixel_value = 1'b0;
   logic [ldt_pkg::COORD_W-1:0]    req_query_row   = '0;
   logic [ldt_pkg::COORD_W-1:0]    req_query_col   = '0;
   logic                           rsp_ready       = 1'b0;
   logic                           csr_valid       = 1'b0;
   logic [ldt_pkg::CSR_IDX_W-1:0]  csr_index       = ldt_pkg::CSR_IMAGE_SIZE;
   logic [ldt_pkg::CSR_DATA_W-1:0] csr_data        = '0;
   logic                           req_ready;
   logic                           rsp_valid;
   logic                           rsp_dense;
   logic [ldt_pkg::SUM_W-1:0]      rsp_window_sum;
   logic [ldt_pkg::AREA_W-1:0]     rsp_window_area;
   logic [ldt_pkg::STATUS_W-1:0]   rsp_status;
   logic                           csr_ready;

   pixel_request_type  pending_requests [$];
   density_result_type expected_results [$];
   pixel_request_type  next_request;
   density_result_type observed_result;
   density_result_type wanted_result;

   int issued_count   = 0;
   int accepted_count = 0;
   int mismatch_count = 0;
   int gap_left       = 0;
   int stall_left     = 0;
   int hold_requests  = 0;
   int holds_served   = 0;
   bit calm_traffic   = 1'b0;

   logic [20:0]                 sat_entry [int];
   logic [ldt_pkg::COORD_W-1:0] row_acc;
   logic [ldt_pkg::COORD_W-1:0] fill_row;
   logic [ldt_pkg::COORD_W-1:0] fill_col;
   logic                        image_full;
   logic [ldt_pkg::COORD_W-1:0] size_reg;
   logic [ldt_pkg::RAD_W-1:0]   radius_reg;
   logic [ldt_pkg::PCT_W-1:0]   percent_reg;

   local_density_threshold_top #(
      .MAX_SIZE(TABLE_SIDE)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_type        (req_type),
      .req_pixel_value (req_pixel_value),
      .req_query_row   (req_query_row),
      .req_query_col   (req_query_col),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_dense       (rsp_dense),
      .rsp_window_sum  (rsp_window_sum),
      .rsp_window_area (rsp_window_area),
      .rsp_status      (rsp_status),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   always #4 clock = ~clock;

   function automatic int draw_pause();
      int roll;
      roll = $urandom_range(99);
      if (calm_traffic || roll < 65) return 0;
      if (roll < 93) return $urandom_range(3, 1);
      return $urandom_range(40, 8);
   endfunction

   function automatic int side_length();
      if (size_reg == '0) return 1;
      if (size_reg > TABLE_SIDE) return TABLE_SIDE;
      return int'(size_reg);
   endfunction

   function automatic int sat_read(int r, int c);
      int key;
      key = (r - 1) * TABLE_SIDE + c - 1;
      if (r == 0 || c == 0 || !sat_entry.exists(key)) return 0;
      return int'(sat_entry[key]);
   endfunction

   function automatic density_result_type density_of_window(int r, int c);
      density_result_type res;
      int n, rad, top, left, bottom, right, total, span;
      n   = side_length();
      rad = int'(radius_reg);
      res.dense       = 1'b0;
      res.window_sum  = '0;
      res.window_area = '0;
      res.status      = ldt_pkg::STATUS_OK;
      if (!image_full) begin
         res.status = ldt_pkg::STATUS_INCOMPLETE;
      end else if (r == 0 || c == 0 || r > n || c > n) begin
         res.status = ldt_pkg::STATUS_RANGE;
      end else begin
         top    = (r > rad + 1) ? r - rad : 1;
         left   = (c > rad + 1) ? c - rad : 1;
         bottom = (r + rad < n) ? r + rad : n;
         right  = (c + rad < n) ? c + rad : n;
         total  = sat_read(bottom, right) - sat_read(top - 1, right)
                - sat_read(bottom, left - 1) + sat_read(top - 1, left - 1);
         span   = (bottom - top + 1) * (right - left + 1);
         res.dense       = (total * int'(ldt_pkg::SCALE) > span * int'(percent_reg));
         res.window_sum  = total[ldt_pkg::SUM_W-1:0];
         res.window_area = span[ldt_pkg::AREA_W-1:0];
      end
      return res;
   endfunction

   task automatic restart_fill();
      row_acc    = '0;
      fill_row   = ldt_pkg::COORD_W'(1);
      fill_col   = ldt_pkg::COORD_W'(1);
      image_full = 1'b0;
   endtask

   task automatic absorb_pixel(input logic px);
      int n, key;
      n = side_length();
      if (!image_full) begin
         row_acc = row_acc + px;
         key = (int'(fill_row) - 1) * TABLE_SIDE + int'(fill_col) - 1;
         sat_entry[key] = 21'(sat_read(int'(fill_row) - 1, int'(fill_col)) + int'(row_acc));
         if (int'(fill_col) >= n) begin
            fill_col = ldt_pkg::COORD_W'(1);
            row_acc  = '0;
            if (int'(fill_row) >= n) image_full = 1'b1;
            else fill_row = fill_row + 1'b1;
         end else begin
            fill_col = fill_col + 1'b1;
         end
      end
   endtask

   task automatic push_load(input logic px);
      pixel_request_type req;
      req.kind  = ldt_pkg::REQ_LOAD;
      req.pixel = px;
      req.row   = ldt_pkg::COORD_W'($urandom_range(2047, 0));
      req.col   = ldt_pkg::COORD_W'($urandom_range(2047, 0));
      pending_requests.insert(pending_requests.size(), req);
      issued_count++;
   endtask

   task automatic push_query(input int r, input int c);
      pixel_request_type req;
      req.kind  = ldt_pkg::REQ_QUERY;
      req.pixel = 1'($urandom_range(1, 0));
      req.row   = ldt_pkg::COORD_W'(r);
      req.col   = ldt_pkg::COORD_W'(c);
      pending_requests.insert(pending_requests.size(), req);
      issued_count++;
   endtask

   function automatic int pick_coord(int n);
      int roll;
      roll = $urandom_range(99);
      if (roll < 12) return ($urandom_range(1, 0) == 0) ? 1 : n;
      if (roll < 82) return $urandom_range(n, 1);
      if (roll < 89) return 0;
      if (roll < 94) return n + 1;
      return $urandom_range(2047, 0);
   endfunction

   function automatic int pick_percent();
      case ($urandom_range(5, 0))
         0: return 0;
         1: return 37;
         2: return 100;
         3: return 127;
         default: return $urandom_range(127, 0);
      endcase
   endfunction

   task automatic write_register(input logic [ldt_pkg::CSR_IDX_W-1:0] idx,
                                 input int value);
      csr_index <= idx;
      csr_data  <= ldt_pkg::CSR_DATA_W'(value);
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         ldt_pkg::CSR_IMAGE_SIZE: begin
            size_reg = ldt_pkg::COORD_W'(value);
            restart_fill();
         end
         ldt_pkg::CSR_RADIUS:  radius_reg  = ldt_pkg::RAD_W'(value);
         ldt_pkg::CSR_PERCENT: percent_reg = ldt_pkg::PCT_W'(value);
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic settle_block();
      while (accepted_count != issued_count || expected_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_valid && req_ready) begin
            accepted_count++;
            if (req_type == ldt_pkg::REQ_QUERY)
               expected_results.insert(expected_results.size(),
                  density_of_window(int'(req_query_row), int'(req_query_col)));
            else
               absorb_pixel(req_pixel_value);
         end
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_requests.size() != 0) begin
               next_request = pending_requests[0];
               pending_requests.delete(0);
               req_type        <= next_request.kind;
               req_pixel_value <= next_request.pixel;
               req_query_row   <= next_request.row;
               req_query_col   <= next_request.col;
               req_valid       <= 1'b1;
               gap_left = draw_pause();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            observed_result.dense       = rsp_dense;
            observed_result.window_sum  = rsp_window_sum;
            observed_result.window_area = rsp_window_area;
            observed_result.status      = rsp_status;
            if (expected_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("%0t: unexpected result dense %0d sum %0d area %0d status %0d",
                           $time, rsp_dense, rsp_window_sum, rsp_window_area, rsp_status);
            end else begin
               wanted_result = expected_results[0];
               expected_results.delete(0);
               if (observed_result !== wanted_result) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_LIMIT) begin
                     $write("%0t: result mismatch, expected dense %0d sum %0d area %0d",
                            $time, wanted_result.dense, wanted_result.window_sum,
                            wanted_result.window_area);
                     $display(" status %0d, got dense %0d sum %0d area %0d status %0d",
                              wanted_result.status, observed_result.dense,
                              observed_result.window_sum, observed_result.window_area,
                              observed_result.status);
                  end
               end
            end
         end
         if (holds_served != hold_requests) begin
            holds_served++;
            stall_left = LONG_HOLD;
         end else if (stall_left == 0 && $urandom_range(3, 0) == 0) begin
            stall_left = draw_pause();
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      #4_000_000;
      $display("FAIL");
      $finish;
   end

   initial begin
      int side, roll, fill_pct, random_items;
      bit held;
      random_items = 0;
      held         = 1'b0;
      size_reg     = ldt_pkg::RESET_IMAGE_SIZE;
      radius_reg   = ldt_pkg::RESET_RADIUS;
      percent_reg  = ldt_pkg::RESET_PERCENT;
      restart_fill();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // reset settings: nothing loaded, so every query reports an incomplete image
      push_query(1, 1);
      push_query(0, 2047);
      push_load(1'b1);
      push_load(1'b0);
      push_query(1024, 1024);
      settle_block();

      // size zero acts as a single pixel; later loads drop
      write_register(ldt_pkg::CSR_IMAGE_SIZE, 0);
      write_register(ldt_pkg::CSR_RADIUS, 7);
      write_register(ldt_pkg::CSR_PERCENT, 0);
      push_load(1'b1);
      push_load(1'b0);
      push_query(1, 1);
      push_query(0, 1);
      push_query(1, 0);
      push_query(2047, 2);
      settle_block();

      write_register(ldt_pkg::CSR_IMAGE_SIZE, 1024);
      push_load(1'b1);
      push_load(1'b1);
      push_query(1024, 1024);
      settle_block();

      // oversize value clamps; restart mid-row
      write_register(ldt_pkg::CSR_IMAGE_SIZE, 2047);
      push_query(1, 1);
      settle_block();

      write_register(ldt_pkg::CSR_IMAGE_SIZE, 3);
      write_register(ldt_pkg::CSR_RADIUS, 1);
      write_register(ldt_pkg::CSR_PERCENT, 100);
      repeat (9) push_load(1'b1);
      push_query(2, 2);
      push_query(1, 1);
      push_query(3, 4);
      settle_block();

      write_register(ldt_pkg::CSR_RADIUS, 0);
      write_register(ldt_pkg::CSR_PERCENT, 127);
      push_query(3, 3);
      settle_block();

      while (random_items < RANDOM_ITEMS) begin
         calm_traffic = ($urandom_range(4, 0) == 0);
         if (image_full && $urandom_range(3, 0) == 0) begin
            if ($urandom_range(1, 0) == 0)
               write_register(ldt_pkg::CSR_RADIUS, $urandom_range(7, 0));
            else
               write_register(ldt_pkg::CSR_PERCENT, pick_percent());
            side = side_length();
         end else begin
            roll = $urandom_range(99);
            if (roll < 5) side = 0;
            else if (roll < 70) side = $urandom_range(6, 1);
            else if (roll < 95) side = $urandom_range(12, 7);
            else side = $urandom_range(16, 13);
            write_register(ldt_pkg::CSR_IMAGE_SIZE, side);
            if ($urandom_range(1, 0) == 0)
               write_register(ldt_pkg::CSR_RADIUS, $urandom_range(7, 0));
            if ($urandom_range(1, 0) == 0)
               write_register(ldt_pkg::CSR_PERCENT, pick_percent());
            side     = side_length();
            fill_pct = $urandom_range(100, 0);
            if (!held) begin
               hold_requests++;
               held = 1'b1;
            end
            for (int i = 0; i < side * side; i++) begin
               if ($urandom_range(9, 0) == 0) begin
                  push_query(pick_coord(side), pick_coord(side));
                  random_items++;
               end
               push_load($urandom_range(99) < fill_pct);
               random_items++;
            end
            repeat ($urandom_range(2, 0)) push_load(1'($urandom_range(1, 0)));
         end
         repeat ($urandom_range(30, 8)) begin
            push_query(pick_coord(side), pick_coord(side));
            random_items++;
         end
         settle_block();
      end

      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
